@@ design/odpam_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpam_pkg
// Shared types, constants and saturating fixed-point helpers of the odd
// polynomial angle map.
// ----------------------------------------------------------------------------
package odpam_pkg;

   localparam int MAX_ROUNDS = 64;
   localparam int ANGLE_BITS = 32;
   localparam int FRAC       = 28;
   localparam int DIV_STEPS  = 64 + FRAC;
   localparam int ROUND_BITS = $clog2(MAX_ROUNDS);
   localparam int DIV_BITS   = $clog2(DIV_STEPS);
   localparam int OUT_BITS   = (ANGLE_BITS < 32) ? ANGLE_BITS : 32;

   typedef logic signed [63:0] s64_type;

   localparam s64_type S64_MAX = {1'b0, {63{1'b1}}};
   localparam s64_type S64_MIN = {1'b1, {63{1'b0}}};
   localparam s64_type OUT_MAX = s64_type'((64'd1 << (OUT_BITS - 1)) - 64'd1);
   localparam s64_type OUT_MIN = -OUT_MAX - s64_type'(1);

   localparam logic [2:0] CSR_MODE      = 3'd0;
   localparam logic [2:0] CSR_COEF_A0   = 3'd1;
   localparam logic [2:0] CSR_COEF_A4   = 3'd5;
   localparam logic [2:0] CSR_MAX_ANGLE = 3'd6;

   localparam logic [1:0] MODE_FWD = 2'd1;
   localparam logic [1:0] MODE_INV = 2'd2;

   localparam logic [47:0] COEF_A0_RESET   = 48'd1 << 40;
   localparam logic [30:0] MAX_ANGLE_RESET = 31'd421657428;

   typedef enum logic [3:0] {
      OP_NOP, OP_LOAD, OP_T2, OP_HINIT, OP_HACC, OP_Y, OP_F,
      OP_TDIV, OP_ROUND, OP_NEWTON, OP_MID, OP_OUT
   } op_type;

   typedef enum logic [1:0] {MS_SQ, MS_HQ, MS_TQ} msel_type;
   typedef enum logic {DS_INIT, DS_NEWTON} dsel_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [4:0][47:0]  coef;
      logic [30:0]       max_angle;
   } cfg_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] k;
      logic       use_cd;
      logic       mul_go;
      msel_type   mul_sel;
      logic       div_go;
      dsel_type   div_sel;
   } cmd_type;

   typedef struct packed {
      logic fwd;
      logic inv;
      logic oor;
      logic a0_pos;
      logic f_zero;
      logic d_pos;
      logic closed;
      logic mul_done;
      logic div_done;
   } status_type;

   function automatic logic [63:0] mag64(s64_type v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

   function automatic s64_type from_mag(logic neg, logic [63:0] m);
      if (neg) begin
         return m[63] ? S64_MIN : s64_type'(~m + 64'd1);
      end
      return m[63] ? S64_MAX : s64_type'(m);
   endfunction

   function automatic s64_type sadd(s64_type a, s64_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

   function automatic s64_type sneg(s64_type a);
      return (a == S64_MIN) ? S64_MAX : -a;
   endfunction

   function automatic s64_type ssub(s64_type a, s64_type b);
      return sadd(a, sneg(b));
   endfunction

   function automatic s64_type q40_to_q28(s64_type c);
      return from_mag(c[63], (mag64(c) + 64'd2048) >> 12);
   endfunction

   function automatic logic [31:0] sat_out(s64_type v);
      if (v > OUT_MAX) begin
         return OUT_MAX[31:0];
      end
      if (v < OUT_MIN) begin
         return OUT_MIN[31:0];
      end
      return v[31:0];
   endfunction

endpackage

@@ design/odpam_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpam_mul
// Signed 64 by 64 Q.28 multiplier built from four 32 by 32 partial products,
// rounded to nearest with ties away from zero and saturated.
// ----------------------------------------------------------------------------
module odpam_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  odpam_pkg::s64_type     a,
   input  odpam_pkg::s64_type     b,
   output odpam_pkg::s64_type     p,
   output logic                   done
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               pv_ff, pv_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [63:0]        ua_ff, ua_in, ub_ff, ub_in;
   logic               neg_ff, neg_in;
   logic [63:0]        pp_ff, pp_in;
   logic [1:0]         sh_ff, sh_in;
   logic [127:0]       acc_ff, acc_in;
   odpam_pkg::s64_type p_ff, p_in;
   logic [127:0]       rnd;
   logic [63:0]        m;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      pv_in   = pv_ff;
      cnt_in  = cnt_ff;
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      neg_in  = neg_ff;
      pp_in   = pp_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      p_in    = p_ff;
      rnd     = acc_ff + (128'd1 << (odpam_pkg::FRAC - 1));
      m       = (rnd[127:64 + odpam_pkg::FRAC] != '0) ? '1 :
                rnd[63 + odpam_pkg::FRAC:odpam_pkg::FRAC];
      if (go) begin
         ua_in   = odpam_pkg::mag64(a);
         ub_in   = odpam_pkg::mag64(b);
         neg_in  = a[63] ^ b[63];
         acc_in  = '0;
         cnt_in  = '0;
         pv_in   = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (pv_ff) begin
            acc_in = acc_ff + ({64'd0, pp_ff} << {sh_ff, 5'd0});
         end
         if (cnt_ff < 3'd4) begin
            pp_in  = {32'd0, ua_ff[cnt_ff[1] * 32 +: 32]} * {32'd0, ub_ff[cnt_ff[0] * 32 +: 32]};
            sh_in  = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
            pv_in  = 1'b1;
            cnt_in = cnt_ff + 3'd1;
         end else if (cnt_ff == 3'd4) begin
            pv_in  = 1'b0;
            cnt_in = cnt_ff + 3'd1;
         end else begin
            p_in    = odpam_pkg::from_mag(neg_ff, m);
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pv_ff   <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         pv_ff   <= pv_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      neg_ff <= neg_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      p_ff   <= p_in;
   end

   assign p    = p_ff;
   assign done = done_ff;

endmodule

@@ design/odpam_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpam_div
// Restoring divider, one quotient bit per cycle, giving floor(n * 2^28 / d)
// saturated to the positive 64-bit range.
// ----------------------------------------------------------------------------
module odpam_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] n,
   input  logic [63:0] d,
   output logic [63:0] q,
   output logic        done
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [odpam_pkg::DIV_BITS-1:0] cnt_ff, cnt_in;
   logic [63:0]                   nsh_ff, nsh_in;
   logic [63:0]                   d_ff, d_in;
   logic [63:0]                   r_ff, r_in;
   logic [63:0]                   q_ff, q_in;
   logic                          sat_ff, sat_in;
   logic [64:0]                   rs;
   logic [64:0]                   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      nsh_in  = nsh_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      rs      = {r_ff, nsh_ff[63]};
      diff    = rs - {1'b0, d_ff};
      if (go) begin
         nsh_in  = n;
         d_in    = d;
         r_in    = '0;
         q_in    = '0;
         sat_in  = 1'b0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         nsh_in = {nsh_ff[62:0], 1'b0};
         sat_in = sat_ff | (q_ff[63:62] != 2'b00);
         if (rs >= {1'b0, d_ff}) begin
            r_in = diff[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = rs[63:0];
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == odpam_pkg::DIV_BITS'(odpam_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      nsh_ff <= nsh_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   assign q    = (sat_ff || q_ff[63]) ? odpam_pkg::S64_MAX : q_ff;
   assign done = done_ff;

endmodule

@@ design/odpam_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpam_dp
// Datapath: working registers of the curve evaluation and of the bracketed
// Newton solver, with the shared multiplier and divider.
// ----------------------------------------------------------------------------
module odpam_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  odpam_pkg::cfg_type     cfg,
   input  logic [31:0]            req_angle_in,
   input  odpam_pkg::cmd_type     cmd,
   output odpam_pkg::status_type  st,
   output logic [31:0]            rsp_angle_out,
   output logic                   rsp_out_of_range
);

   logic [1:0]         mode_ff, mode_in;
   logic               neg_ff, neg_in;
   logic               oor_ff, oor_in;
   logic               flag_ff, flag_in;
   logic [31:0]        angle_ff, angle_in;
   odpam_pkg::s64_type x_ff, x_in, target_ff, target_in;
   odpam_pkg::s64_type lo_ff, lo_in, up_ff, up_in, t_ff, t_in, ev_ff, ev_in;
   odpam_pkg::s64_type t2_ff, t2_in, q_ff, q_in, f_ff, f_in;
   odpam_pkg::s64_type cg_ff [5];
   odpam_pkg::s64_type cg_in [5];
   odpam_pkg::s64_type cd_ff [5];
   odpam_pkg::s64_type cd_in [5];

   odpam_pkg::s64_type mul_a, mul_b, mul_p, coef_sel, top_sel, mid, fnew, a_ext, v;
   logic [63:0]        div_n, div_d, div_q;
   logic               mul_done, div_done;

   odpam_mul u_mul (
      .clock (clock), .reset (reset), .go (cmd.mul_go),
      .a (mul_a), .b (mul_b), .p (mul_p), .done (mul_done)
   );

   odpam_div u_div (
      .clock (clock), .reset (reset), .go (cmd.div_go),
      .n (div_n), .d (div_d), .q (div_q), .done (div_done)
   );

   always_comb begin
      case (cmd.mul_sel)
         odpam_pkg::MS_SQ: begin
            mul_a = ev_ff;
            mul_b = ev_ff;
         end
         odpam_pkg::MS_HQ: begin
            mul_a = t2_ff;
            mul_b = q_ff;
         end
         default: begin
            mul_a = ev_ff;
            mul_b = q_ff;
         end
      endcase
      if (cmd.div_sel == odpam_pkg::DS_INIT) begin
         div_n = target_ff;
         div_d = cg_ff[0];
      end else begin
         div_n = odpam_pkg::mag64(f_ff);
         div_d = q_ff;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      neg_in    = neg_ff;
      oor_in    = oor_ff;
      flag_in   = flag_ff;
      angle_in  = angle_ff;
      x_in      = x_ff;
      target_in = target_ff;
      lo_in     = lo_ff;
      up_in     = up_ff;
      t_in      = t_ff;
      ev_in     = ev_ff;
      t2_in     = t2_ff;
      q_in      = q_ff;
      f_in      = f_ff;
      cg_in     = cg_ff;
      cd_in     = cd_ff;
      coef_sel  = cmd.use_cd ? cd_ff[{1'b0, cmd.k}] : cg_ff[{1'b0, cmd.k}];
      top_sel   = cmd.use_cd ? cd_ff[4] : cg_ff[4];
      mid       = (lo_ff + up_ff) >>> 1;
      fnew      = odpam_pkg::ssub(mul_p, target_ff);
      a_ext     = '0;
      if (mode_ff == odpam_pkg::MODE_FWD) begin
         v = f_ff;
      end else if (mode_ff == odpam_pkg::MODE_INV) begin
         v = oor_ff ? '0 : (neg_ff ? odpam_pkg::sneg(t_ff) : t_ff);
      end else begin
         v = x_ff;
      end
      case (cmd.op)
         odpam_pkg::OP_LOAD: begin
            mode_in   = cfg.mode;
            x_in      = {{32{req_angle_in[31]}}, req_angle_in};
            neg_in    = req_angle_in[31];
            target_in = odpam_pkg::mag64({{32{req_angle_in[31]}}, req_angle_in});
            lo_in     = '0;
            up_in     = {33'd0, cfg.max_angle};
            t_in      = -odpam_pkg::s64_type'(1);
            ev_in     = (cfg.mode == odpam_pkg::MODE_INV) ? {33'd0, cfg.max_angle} :
                        {{32{req_angle_in[31]}}, req_angle_in};
            oor_in    = 1'b0;
            for (int k = 0; k < 5; k++) begin
               a_ext    = {{16{cfg.coef[k][47]}}, cfg.coef[k]};
               cg_in[k] = odpam_pkg::q40_to_q28(a_ext);
               cd_in[k] = odpam_pkg::q40_to_q28(a_ext * odpam_pkg::s64_type'(2 * k + 1));
            end
         end
         odpam_pkg::OP_T2: begin
            t2_in = mul_p;
            q_in  = top_sel;
         end
         odpam_pkg::OP_HINIT: begin
            q_in = top_sel;
         end
         odpam_pkg::OP_HACC: begin
            q_in = odpam_pkg::sadd(coef_sel, mul_p);
         end
         odpam_pkg::OP_Y: begin
            f_in   = mul_p;
            oor_in = target_ff > mul_p;
         end
         odpam_pkg::OP_F: begin
            f_in = fnew;
            if (fnew > 0) begin
               up_in = t_ff;
            end else begin
               lo_in = t_ff;
            end
         end
         odpam_pkg::OP_TDIV: begin
            t_in = div_q;
         end
         odpam_pkg::OP_ROUND: begin
            if (!(t_ff > lo_ff && t_ff < up_ff)) begin
               t_in  = mid;
               ev_in = mid;
            end else begin
               ev_in = t_ff;
            end
         end
         odpam_pkg::OP_NEWTON: begin
            t_in = odpam_pkg::ssub(t_ff, odpam_pkg::from_mag(f_ff[63], div_q));
         end
         odpam_pkg::OP_MID: begin
            t_in = mid;
         end
         odpam_pkg::OP_OUT: begin
            angle_in = odpam_pkg::sat_out(v);
            flag_in  = (mode_ff == odpam_pkg::MODE_INV) && oor_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      neg_ff    <= neg_in;
      oor_ff    <= oor_in;
      flag_ff   <= flag_in;
      angle_ff  <= angle_in;
      x_ff      <= x_in;
      target_ff <= target_in;
      lo_ff     <= lo_in;
      up_ff     <= up_in;
      t_ff      <= t_in;
      ev_ff     <= ev_in;
      t2_ff     <= t2_in;
      q_ff      <= q_in;
      f_ff      <= f_in;
      cg_ff     <= cg_in;
      cd_ff     <= cd_in;
   end

   assign st.fwd      = (mode_ff == odpam_pkg::MODE_FWD);
   assign st.inv      = (mode_ff == odpam_pkg::MODE_INV);
   assign st.oor      = oor_ff;
   assign st.a0_pos   = (cg_ff[0] > 0);
   assign st.f_zero   = (f_ff == 0);
   assign st.d_pos    = (q_ff > 0);
   assign st.closed   = !(up_ff > lo_ff);
   assign st.mul_done = mul_done;
   assign st.div_done = div_done;

   assign rsp_angle_out    = angle_ff;
   assign rsp_out_of_range = flag_ff;

endmodule

@@ design/odpam_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpam_ctrl
// Sequencer of the angle map: Horner evaluation, range check, and the
// rounds of the safeguarded Newton solver.
// ----------------------------------------------------------------------------
module odpam_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  odpam_pkg::status_type  st,
   output odpam_pkg::cmd_type     cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_LOAD  = 11'b00000000010,
      S_SQ    = 11'b00000000100,
      S_HQ    = 11'b00000001000,
      S_TQ    = 11'b00000010000,
      S_POST  = 11'b00000100000,
      S_DIV0  = 11'b00001000000,
      S_ROUND = 11'b00010000000,
      S_SLOPE = 11'b00100000000,
      S_NEXT  = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   typedef enum logic [1:0] {PH_FWD, PH_CHECK, PH_LOOP_F, PH_LOOP_D} phase_type;

   state_type                        state_ff, state_in;
   phase_type                        phase_ff, phase_in;
   logic                             issued_ff, issued_in;
   logic                             valid_ff, valid_in;
   logic [1:0]                       k_ff, k_in;
   logic [odpam_pkg::ROUND_BITS-1:0] round_ff, round_in;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      issued_in   = issued_ff;
      valid_in    = 1'b0;
      k_in        = k_ff;
      round_in    = round_ff;
      cmd.op      = odpam_pkg::OP_NOP;
      cmd.k       = k_ff;
      cmd.use_cd  = (phase_ff == PH_LOOP_D);
      cmd.mul_go  = 1'b0;
      cmd.mul_sel = odpam_pkg::MS_SQ;
      cmd.div_go  = 1'b0;
      cmd.div_sel = odpam_pkg::DS_INIT;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = odpam_pkg::OP_LOAD;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (st.fwd) begin
               phase_in = PH_FWD;
               state_in = S_SQ;
            end else if (st.inv) begin
               phase_in = PH_CHECK;
               state_in = S_SQ;
            end else begin
               state_in = S_OUT;
            end
         end
         S_SQ: begin
            cmd.mul_sel = odpam_pkg::MS_SQ;
            if (!issued_ff) begin
               cmd.mul_go = 1'b1;
               issued_in  = 1'b1;
            end else if (st.mul_done) begin
               cmd.op     = odpam_pkg::OP_T2;
               cmd.use_cd = 1'b0;
               issued_in  = 1'b0;
               k_in       = 2'd3;
               state_in   = S_HQ;
            end
         end
         S_HQ: begin
            cmd.mul_sel = odpam_pkg::MS_HQ;
            if (!issued_ff) begin
               cmd.mul_go = 1'b1;
               issued_in  = 1'b1;
            end else if (st.mul_done) begin
               cmd.op    = odpam_pkg::OP_HACC;
               issued_in = 1'b0;
               if (k_ff == 2'd0) begin
                  state_in = (phase_ff == PH_LOOP_D) ? S_SLOPE : S_TQ;
               end else begin
                  k_in = k_ff - 2'd1;
               end
            end
         end
         S_TQ: begin
            cmd.mul_sel = odpam_pkg::MS_TQ;
            if (!issued_ff) begin
               cmd.mul_go = 1'b1;
               issued_in  = 1'b1;
            end else if (st.mul_done) begin
               cmd.op    = (phase_ff == PH_LOOP_F) ? odpam_pkg::OP_F : odpam_pkg::OP_Y;
               issued_in = 1'b0;
               state_in  = S_POST;
            end
         end
         S_POST: begin
            case (phase_ff)
               PH_CHECK: begin
                  round_in = '0;
                  if (st.oor) begin
                     state_in = S_OUT;
                  end else if (st.a0_pos) begin
                     state_in = S_DIV0;
                  end else begin
                     state_in = S_ROUND;
                  end
               end
               PH_LOOP_F: begin
                  if (st.f_zero) begin
                     state_in = S_OUT;
                  end else begin
                     cmd.op     = odpam_pkg::OP_HINIT;
                     cmd.use_cd = 1'b1;
                     phase_in   = PH_LOOP_D;
                     k_in       = 2'd3;
                     state_in   = S_HQ;
                  end
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_DIV0: begin
            cmd.div_sel = odpam_pkg::DS_INIT;
            if (!issued_ff) begin
               cmd.div_go = 1'b1;
               issued_in  = 1'b1;
            end else if (st.div_done) begin
               cmd.op    = odpam_pkg::OP_TDIV;
               issued_in = 1'b0;
               state_in  = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.op   = odpam_pkg::OP_ROUND;
            phase_in = PH_LOOP_F;
            state_in = S_SQ;
         end
         S_SLOPE: begin
            cmd.div_sel = odpam_pkg::DS_NEWTON;
            if (!st.d_pos) begin
               cmd.op   = odpam_pkg::OP_MID;
               state_in = S_NEXT;
            end else if (!issued_ff) begin
               cmd.div_go = 1'b1;
               issued_in  = 1'b1;
            end else if (st.div_done) begin
               cmd.op    = odpam_pkg::OP_NEWTON;
               issued_in = 1'b0;
               state_in  = S_NEXT;
            end
         end
         S_NEXT: begin
            if (st.closed ||
                round_ff == odpam_pkg::ROUND_BITS'(odpam_pkg::MAX_ROUNDS - 1)) begin
               state_in = S_OUT;
            end else begin
               round_in = round_ff + 1'b1;
               state_in = S_ROUND;
            end
         end
         S_OUT: begin
            cmd.op   = odpam_pkg::OP_OUT;
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= PH_FWD;
         issued_ff <= 1'b0;
         valid_ff  <= 1'b0;
         k_ff      <= '0;
         round_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         issued_ff <= issued_in;
         valid_ff  <= valid_in;
         k_ff      <= k_in;
         round_ff  <= round_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

@@ design/odd_polynomial_angle_map_inverse_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_polynomial_angle_map_inverse_top
// Maps a Q3.28 angle through an odd ninth-order polynomial, through its
// inverse by a bracketed Newton solver, or passes it through.
//
//   channel   ports                               transfer
//   input     start, busy, req_angle_in           start && !busy
//   result    rsp_valid, rsp_angle_out,           rsp_valid, one cycle
//             rsp_out_of_range
//   config    csr_we, csr_index, csr_wdata        csr_we
//
// The forward curve takes six products on the shared multiplier of four
// 32 by 32 partial products. The inverse runs the range check and the
// start division, then each solver round takes up to ten products and
// one divide.
// Reset is synchronous; busy drops in the cycle of the result strobe.
// The receiver cannot stall the block, so no result ever waits.
// ----------------------------------------------------------------------------
module odd_polynomial_angle_map_inverse_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_angle_in,
   output logic        rsp_valid,
   output logic [31:0] rsp_angle_out,
   output logic        rsp_out_of_range,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   odpam_pkg::cfg_type    cfg_ff, cfg_in;
   odpam_pkg::cmd_type    cmd;
   odpam_pkg::status_type st;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index) inside
            odpam_pkg::CSR_MODE: begin
               cfg_in.mode = csr_wdata[1:0];
            end
            [odpam_pkg::CSR_COEF_A0:odpam_pkg::CSR_COEF_A4]: begin
               cfg_in.coef[csr_index - odpam_pkg::CSR_COEF_A0] = csr_wdata;
            end
            odpam_pkg::CSR_MAX_ANGLE: begin
               cfg_in.max_angle = csr_wdata[30:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode      <= '0;
         cfg_ff.coef      <= {192'd0, odpam_pkg::COEF_A0_RESET};
         cfg_ff.max_angle <= odpam_pkg::MAX_ANGLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   odpam_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start), .st (st),
      .cmd (cmd), .busy (busy), .rsp_valid (rsp_valid)
   );

   odpam_dp u_dp (
      .clock (clock), .reset (reset), .cfg (cfg_ff), .req_angle_in (req_angle_in),
      .cmd (cmd), .st (st), .rsp_angle_out (rsp_angle_out),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

@@ design/odpam_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpam_port_checks
// Port-level checks of the angle map: strobe spacing, busy behavior and the
// out-of-range result.
// ----------------------------------------------------------------------------
module odpam_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_angle_out,
   input logic        rsp_out_of_range
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_idle_at_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy high while a result word is shown");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_angle_out == 32'd0)
      else $error("out-of-range result word is not zero");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !busy && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind odd_polynomial_angle_map_inverse_top odpam_port_checks u_odpam_port_checks (
   .clock (clock), .reset (reset), .start (start), .busy (busy),
   .rsp_valid (rsp_valid), .rsp_angle_out (rsp_angle_out),
   .rsp_out_of_range (rsp_out_of_range)
);

@@ dv/odpam_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpam_checker
// Watches the command, result and register ports of the angle map, mirrors
// the register file, predicts each result word in Q.28 fixed point and
// compares it field by field with the word the block returns.
// ----------------------------------------------------------------------------
module odpam_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_angle_in,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_angle_out,
   input  logic        rsp_out_of_range,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      logic [31:0] angle;
      logic        oor;
   } mapped_word_type;

   mapped_word_type  mapped_q[$];
   logic [1:0]       mode_r;
   logic [4:0][47:0] coef_r;
   logic [30:0]      max_angle_r;

   function automatic logic [63:0] umag(odpam_pkg::s64_type v);
      return v < 0 ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   function automatic odpam_pkg::s64_type pack_sat(logic neg, logic [63:0] m);
      if (neg) begin
         return m >= 64'h8000_0000_0000_0000 ? odpam_pkg::S64_MIN :
                -odpam_pkg::s64_type'(m);
      end
      return m[63] ? odpam_pkg::S64_MAX : odpam_pkg::s64_type'(m);
   endfunction

   function automatic odpam_pkg::s64_type add_s(odpam_pkg::s64_type a,
                                                odpam_pkg::s64_type b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(odpam_pkg::S64_MAX)) return odpam_pkg::S64_MAX;
      if (s < 65'(odpam_pkg::S64_MIN)) return odpam_pkg::S64_MIN;
      return s[63:0];
   endfunction

   function automatic odpam_pkg::s64_type sub_s(odpam_pkg::s64_type a,
                                                odpam_pkg::s64_type b);
      return add_s(a, b == odpam_pkg::S64_MIN ? odpam_pkg::S64_MAX : -b);
   endfunction

   function automatic odpam_pkg::s64_type mulq(odpam_pkg::s64_type a,
                                               odpam_pkg::s64_type b);
      logic [127:0] p;
      logic         neg;
      neg = (a < 0) != (b < 0);
      p = {64'd0, umag(a)} * {64'd0, umag(b)} + (128'd1 << (odpam_pkg::FRAC - 1));
      if (p[127:92] != 0) return pack_sat(neg, '1);
      return pack_sat(neg, p[91:28]);
   endfunction

   function automatic odpam_pkg::s64_type to_q28(odpam_pkg::s64_type c);
      return pack_sat(c < 0, (umag(c) + 64'd2048) >> 12);
   endfunction

   function automatic logic [63:0] divq28(logic [63:0] n, logic [63:0] d);
      logic [91:0] q;
      q = {n, 28'd0} / {28'd0, d};
      if (q[91:63] != 0) return 64'(odpam_pkg::S64_MAX);
      return q[63:0];
   endfunction

   function automatic odpam_pkg::s64_type poly(odpam_pkg::s64_type t,
                                               odpam_pkg::s64_type c[5]);
      odpam_pkg::s64_type t2, acc;
      t2 = mulq(t, t);
      acc = c[4];
      for (int k = 3; k >= 0; k--) acc = add_s(c[k], mulq(t2, acc));
      return acc;
   endfunction

   function automatic odpam_pkg::s64_type curve_at(odpam_pkg::s64_type t,
                                                   odpam_pkg::s64_type c[5]);
      return mulq(t, poly(t, c));
   endfunction

   function automatic odpam_pkg::s64_type solve_inverse(odpam_pkg::s64_type x,
                                                        odpam_pkg::s64_type cg[5],
                                                        odpam_pkg::s64_type cd[5],
                                                        output logic oor);
      odpam_pkg::s64_type target, lo, up, t, f, d;
      logic               neg;
      neg = x < 0;
      target = odpam_pkg::s64_type'(umag(x));
      lo = 0;
      up = odpam_pkg::s64_type'({33'd0, max_angle_r});
      t = -1;
      oor = 1'b0;
      if (target > curve_at(up, cg)) begin
         oor = 1'b1;
         return 0;
      end
      if (cg[0] > 0) t = odpam_pkg::s64_type'(divq28(64'(target), 64'(cg[0])));
      for (int r = 0; r < odpam_pkg::MAX_ROUNDS; r++) begin
         if (!(t > lo && t < up)) t = (lo + up) / 2;
         f = sub_s(curve_at(t, cg), target);
         if (f == 0) break;
         if (f > 0) up = t;
         else lo = t;
         d = poly(t, cd);
         if (d > 0) t = sub_s(t, pack_sat(f < 0, divq28(umag(f), 64'(d))));
         else t = (lo + up) / 2;
         if (up - lo < 1) break;
      end
      return neg ? (t == odpam_pkg::S64_MIN ? odpam_pkg::S64_MAX : -t) : t;
   endfunction

   function automatic mapped_word_type map_angle(logic [31:0] angle_in);
      odpam_pkg::s64_type cg[5], cd[5], a, x, v;
      mapped_word_type    w;
      logic               oor;
      oor = 1'b0;
      x = odpam_pkg::s64_type'($signed(angle_in));
      for (int k = 0; k < 5; k++) begin
         a = odpam_pkg::s64_type'($signed(coef_r[k]));
         cg[k] = to_q28(a);
         cd[k] = to_q28(a * (2 * k + 1));
      end
      if (mode_r == odpam_pkg::MODE_FWD) v = curve_at(x, cg);
      else if (mode_r == odpam_pkg::MODE_INV) v = solve_inverse(x, cg, cd, oor);
      else v = x;
      if (v > odpam_pkg::OUT_MAX) v = odpam_pkg::OUT_MAX;
      if (v < odpam_pkg::OUT_MIN) v = odpam_pkg::OUT_MIN;
      w.angle = v[31:0];
      w.oor = oor;
      return w;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s got %h expected %h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      mapped_word_type w;
      if (reset) begin
         mode_r <= 2'd0;
         coef_r <= {48'd0, 48'd0, 48'd0, 48'd0, odpam_pkg::COEF_A0_RESET};
         max_angle_r <= odpam_pkg::MAX_ANGLE_RESET;
         mapped_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == odpam_pkg::CSR_MODE) mode_r <= csr_wdata[1:0];
            else if (csr_index >= odpam_pkg::CSR_COEF_A0 &&
                     csr_index <= odpam_pkg::CSR_COEF_A4)
               coef_r[csr_index - odpam_pkg::CSR_COEF_A0] <= csr_wdata;
            else if (csr_index == odpam_pkg::CSR_MAX_ANGLE)
               max_angle_r <= csr_wdata[30:0];
         end
         if (start && !busy) mapped_q.insert(mapped_q.size(), map_angle(req_angle_in));
         if (rsp_valid) begin
            if (mapped_q.size() == 0) begin
               report("unexpected word", 64'(rsp_angle_out), 64'd0);
            end else begin
               w = mapped_q.pop_front();
               if (rsp_angle_out !== w.angle) report("angle_out", rsp_angle_out, w.angle);
               if (rsp_out_of_range !== w.oor)
                  report("out_of_range", rsp_out_of_range, w.oor);
            end
         end
      end
      pending = mapped_q.size();
   end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the angle map with directed and random angles under a range of
// register settings, with random gaps between command words, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] MODE_PASS  = 2'd0;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int         STALL_LIMIT = 40000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_angle_in;
   logic        rsp_valid;
   logic [31:0] rsp_angle_out;
   logic        rsp_out_of_range;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [47:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          gap_pct;
   int          stall_cycles;
   logic [30:0] max_angle_set;

   odd_polynomial_angle_map_inverse_top u_top (.*);
   odpam_checker u_checker (.*);

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_word(logic [31:0] angle);
      req_angle_in <= angle;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_regs(logic [1:0] mode, logic [4:0][47:0] coef, logic [30:0] amax);
      csr_we <= 1'b1;
      csr_index <= odpam_pkg::CSR_MODE;
      csr_wdata <= {46'd0, mode};
      @(posedge clock);
      for (int k = 0; k < 5; k++) begin
         csr_index <= odpam_pkg::CSR_COEF_A0 + 3'(k);
         csr_wdata <= coef[k];
         @(posedge clock);
      end
      csr_index <= odpam_pkg::CSR_MAX_ANGLE;
      csr_wdata <= {17'd0, amax};
      @(posedge clock);
      csr_we <= 1'b0;
      max_angle_set = amax;
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic random_phase(int n);
      logic [4:0][47:0] coef;
      logic [30:0]      amax;
      logic [1:0]       mode;
      logic [31:0]      a;
      int               pick;
      pick = $urandom_range(0, 5);
      case (pick)
         0: coef = {48'd0, 48'd0, 48'd0, 48'd0, odpam_pkg::COEF_A0_RESET};
         1: coef = {48'd0, 48'd0, rand48() >> 12, -(rand48() >> 8),
                    odpam_pkg::COEF_A0_RESET};
         2: coef = {rand48(), rand48(), rand48(), rand48(), rand48()};
         3: coef = {5{48'h7FFF_FFFF_FFFF}};
         4: coef = {5{48'h8000_0000_0000}};
         default: coef = {48'd0, rand48() >> 16, rand48() >> 14, rand48() >> 10,
                          rand48() >> 6};
      endcase
      case ($urandom_range(0, 3))
         0: amax = 31'd1;
         1: amax = 31'h7FFF_FFFF;
         2: amax = 31'd1 << 28;
         default: amax = 31'($urandom_range(1, 31'h7FFF_FFFF));
      endcase
      case ($urandom_range(0, 5))
         0: mode = MODE_PASS;
         1: mode = odpam_pkg::MODE_FWD;
         2: mode = MODE_SPARE;
         default: mode = odpam_pkg::MODE_INV;
      endcase
      write_regs(mode, coef, amax);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0) a = $urandom;
         else a = $urandom_range(0, max_angle_set);
         if ($urandom_range(0, 1)) a = -a;
         send_word(a);
      end
      drain();
   endtask

   initial begin
      logic [31:0] edge_angles[8];
      logic [1:0]  modes[4];
      edge_angles = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h1000_0000, 32'hF000_0000, 32'h0800_0000};
      modes = '{MODE_PASS, odpam_pkg::MODE_FWD, odpam_pkg::MODE_INV, MODE_SPARE};
      start = 1'b0;
      req_angle_in = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      gap_pct = 37;
      max_angle_set = odpam_pkg::MAX_ANGLE_RESET;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int m = 0; m < 4; m++) begin
         write_regs(modes[m], {48'd0, 48'd0, -(48'd1 << 36), 48'd0,
                               odpam_pkg::COEF_A0_RESET},
                    odpam_pkg::MAX_ANGLE_RESET);
         for (int i = 0; i < 5; i++) send_word(edge_angles[(i + 2 * m) % 8]);
         drain();
      end
      write_regs(odpam_pkg::MODE_INV, {48'd0, 48'd0, 48'd0, 48'd0, -(48'd1 << 40)},
                 31'd1 << 28);
      send_word(32'h0400_0000);
      send_word(32'hFC00_0000);
      drain();

      for (int p = 0; p < 9; p++) begin
         gap_pct = (p < 3) ? 37 : (p < 6) ? 69 : 0;
         random_phase(22);
      end

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/odpam_pkg.sv
design/odpam_mul.sv
design/odpam_div.sv
design/odpam_dp.sv
design/odpam_ctrl.sv
design/odd_polynomial_angle_map_inverse_top.sv
design/odpam_checker.sv
dv/odpam_checker.sv
dv/tb.sv
